FILE: hdl/integer_array_sorter_assert.svh
// Assertion macros for the integer array sorter checker.
`ifndef INTEGER_ARRAY_SORTER_ASSERT_SVH
`define INTEGER_ARRAY_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ISORT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ISORT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/isort_pkg.sv
// Shared types and constants of the integer array sorter.
package isort_pkg;

	localparam int DATA_W = 32;
	localparam int MAX_ITEMS_DEF = 64;

	typedef struct packed {
		logic                     valid;
		logic                     lt;
		logic signed [DATA_W-1:0] val;
	} link_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} ctrl_t;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

FILE: hdl/integer_array_sorter.sv
// Top level of the integer array sorter: control plus a chain of insertion cells.
// The sorter takes one value per cycle while busy is low; each accepted value is
// placed into its sorted position in the cell chain by the next edge. The transaction
// with last_in high closes the set. From the next cycle busy stays high while the n
// stored values (n is at most MAX_ITEMS) are delivered: one result per cycle
// appears with strobe high, smallest first, as the chain shifts toward its head;
// the receiver cannot stall, so every strobe cycle is a delivered result. Values
// beyond MAX_ITEMS are dropped and flag overflow on every result of that set. The
// first transaction of the next set is taken in the cycle after the result marked
// last_out.
module integer_array_sorter #(
	parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [isort_pkg::DATA_W-1:0] value,
	input  logic                              last_in,
	output logic                              busy,
	output logic                              strobe,
	output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_out,
	output logic                              overflow
);

	isort_pkg::ctrl_t ctrl;
	isort_pkg::link_t link [MAX_ITEMS];
	isort_pkg::link_t head;
	isort_pkg::link_t tail;

	assign head.valid = 1'b1;
	assign head.lt    = 1'b0;
	assign head.val   = '0;
	assign tail.valid = 1'b0;
	assign tail.lt    = 1'b0;
	assign tail.val   = '0;

	isort_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_in (last_in),
		.busy    (busy),
		.ctrl    (ctrl),
		.strobe  (strobe),
		.last_out(last_out),
		.overflow(overflow)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		isort_pkg::link_t left;
		isort_pkg::link_t right;

		if (i == 0) begin : g_first
			assign left = head;
		end else begin : g_mid_l
			assign left = link[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_last
			assign right = tail;
		end else begin : g_mid_r
			assign right = link[i+1];
		end

		isort_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.din   (value),
			.left  (left),
			.right (right),
			.link  (link[i])
		);
	end

	assign sorted_value = link[0].val;

endmodule

FILE: hdl/isort_cell.sv
// One cell of the insertion chain: holds one value and trades it with its neighbors.
module isort_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  isort_pkg::ctrl_t                  ctrl,
	input  logic signed [isort_pkg::DATA_W-1:0] din,
	input  isort_pkg::link_t                  left,
	input  isort_pkg::link_t                  right,
	output isort_pkg::link_t                  link
);

	logic                               valid_q;
	logic signed [isort_pkg::DATA_W-1:0] val_q;
	logic                               below;
	logic                               take_new;

	assign below    = din < val_q;
	assign take_new = left.valid && (!valid_q || below);

	assign link.valid = valid_q;
	assign link.lt    = valid_q && below;
	assign link.val   = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right.valid;
		end else if (ctrl.ins && (left.lt || take_new)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= right.val;
		end else if (ctrl.ins && left.lt) begin
			val_q <= left.val;
		end else if (ctrl.ins && take_new) begin
			val_q <= din;
		end
	end

endmodule

FILE: hdl/isort_ctrl.sv
// Load and drain sequencing, item count and overflow tracking of the sorter.
module isort_ctrl #(
	parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             last_in,
	output logic             busy,
	output isort_pkg::ctrl_t ctrl,
	output logic             strobe,
	output logic             last_out,
	output logic             overflow
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);
	localparam logic [CW-1:0] ONE  = CW'(1);

	isort_pkg::state_t state_q;
	logic [CW-1:0]     cnt_q;
	logic              drop_q;
	logic              accept;
	logic              full;

	assign accept = start && (state_q == isort_pkg::ST_LOAD);
	assign full   = (cnt_q == FULL);

	assign busy       = (state_q == isort_pkg::ST_DRAIN);
	assign strobe     = busy;
	assign last_out   = busy && (cnt_q == ONE);
	assign overflow   = busy && drop_q;
	assign ctrl.ins   = accept && !full;
	assign ctrl.shift = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isort_pkg::ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				isort_pkg::ST_LOAD: begin
					if (accept) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + ONE;
						end
						if (last_in) begin
							state_q <= isort_pkg::ST_DRAIN;
						end
					end
				end
				isort_pkg::ST_DRAIN: begin
					cnt_q <= cnt_q - ONE;
					if (cnt_q == ONE) begin
						state_q <= isort_pkg::ST_LOAD;
						drop_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= isort_pkg::ST_LOAD;
				end
			endcase
		end
	end

endmodule

FILE: hdl/isort_chk.sv
// Port-level checker for the integer array sorter and its bind statement.
`include "integer_array_sorter_assert.svh"

module isort_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic last_in,
	input logic busy,
	input logic strobe,
	input logic last_out,
	input logic overflow
);

	`ISORT_ASSERT_NOW(a_strobe_busy, strobe, busy, "result shown while not busy")
	`ISORT_ASSERT_NEXT(a_close_drains, start && !busy && last_in, strobe, "closing transaction not followed by results")
	`ISORT_ASSERT_NEXT(a_open_quiet, start && !busy && !last_in, !strobe, "result after a non-closing transaction")
	`ISORT_ASSERT_NEXT(a_last_frees, strobe && last_out, !busy, "busy held after the final result")
	`ISORT_ASSERT_NEXT(a_run_steady, strobe && !last_out, strobe && $stable(overflow), "result run broken or overflow changed")

endmodule

bind integer_array_sorter isort_chk u_isort_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.last_in (last_in),
	.busy    (busy),
	.strobe  (strobe),
	.last_out(last_out),
	.overflow(overflow)
);

FILE: test/integer_array_sorter_tb.sv
// Self-checking testbench for the integer array sorter: directed and random sets with scoreboard.
module integer_array_sorter_tb;

	localparam int SET_CAP = isort_pkg::MAX_ITEMS_DEF;
	localparam int W = isort_pkg::DATA_W;
	localparam int ITEM_TARGET = 380;

	typedef struct {
		logic signed [W-1:0] val;
		logic                last;
		logic                ovf;
	} sorted_entry_t;

	class sorted_set_tracker;
		logic signed [W-1:0] held[SET_CAP];
		int                  held_count;
		bit                  dropped;
		sorted_entry_t       expected_order[$];
		int                  errors;

		function new();
			held_count = 0;
			dropped = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_order.size();
		endfunction

		// Records one accepted transaction; a closing one queues the whole sorted set.
		function void note_value(logic signed [W-1:0] v, bit closes);
			logic signed [W-1:0] work[SET_CAP];
			logic signed [W-1:0] key;
			sorted_entry_t e;
			int i;
			int j;
			if (held_count < SET_CAP) begin
				held[held_count] = v;
				held_count++;
			end else begin
				dropped = 1;
			end
			if (!closes)
				return;
			for (i = 0; i < held_count; i++)
				work[i] = held[i];
			for (i = 1; i < held_count; i++) begin
				key = work[i];
				j = i;
				while (j > 0 && work[j-1] > key) begin
					work[j] = work[j-1];
					j--;
				end
				work[j] = key;
			end
			for (i = 0; i < held_count; i++) begin
				e.val = work[i];
				e.last = (i == held_count - 1);
				e.ovf = dropped;
				expected_order.push_back(e);
			end
			held_count = 0;
			dropped = 0;
		endfunction

		function void check_result(logic signed [W-1:0] v, logic lst, logic ovf);
			sorted_entry_t e;
			if (expected_order.size() == 0) begin
				$error("unexpected result: sorted_value %0d last_out %0b overflow %0b",
					v, lst, ovf);
				errors++;
				return;
			end
			e = expected_order.pop_front();
			if (v !== e.val) begin
				$error("sorted_value: expected %0d, actual %0d", e.val, v);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last_out: expected %0b, actual %0b", e.last, lst);
				errors++;
			end
			if (ovf !== e.ovf) begin
				$error("overflow: expected %0b, actual %0b", e.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic signed [W-1:0] value;
	logic                last_in;
	logic                busy;
	logic                strobe;
	logic signed [W-1:0] sorted_value;
	logic                last_out;
	logic                overflow;

	sorted_set_tracker tracker = new();
	int items_sent;
	bit quiet;

	integer_array_sorter #(
		.MAX_ITEMS(SET_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.value(value),
		.last_in(last_in),
		.busy(busy),
		.strobe(strobe),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.overflow(overflow)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			tracker.check_result(sorted_value, last_out, overflow);
	end

	task automatic send_value(input logic signed [W-1:0] v, input bit closes);
		start <= 1'b1;
		value <= v;
		last_in <= closes;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_value(v, closes);
		items_sent++;
	endtask

	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			value <= $urandom;
			last_in <= 1'($urandom_range(0, 1));
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic random_gap();
		int pick;
		pick = $urandom_range(0, 9);
		if (quiet || pick < 6)
			return;
		if (pick < 9)
			idle_for($urandom_range(1, 3));
		else
			idle_for($urandom_range(10, 40));
	endtask

	task automatic wait_all_sorted();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() > 0)
			@(posedge clk);
	endtask

	function automatic logic signed [W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(W-1){1'b0}}};
			1: return {1'b0, {(W-1){1'b1}}};
			2, 3: return $signed($urandom_range(0, 6)) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_set(input logic signed [W-1:0] vals[$]);
		int i;
		for (i = 0; i < vals.size(); i++) begin
			send_value(vals[i], i == vals.size() - 1);
			random_gap();
		end
	endtask

	task automatic send_random_set(input int size);
		int i;
		for (i = 0; i < size; i++) begin
			send_value(random_value(), i == size - 1);
			random_gap();
		end
	endtask

	initial begin
		logic signed [W-1:0] minv;
		logic signed [W-1:0] maxv;
		int set_no;
		int size;
		int pick;
		minv = {1'b1, {(W-1){1'b0}}};
		maxv = {1'b0, {(W-1){1'b1}}};
		items_sent = 0;
		quiet = 0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		last_in = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_set('{minv});
		send_set('{maxv});
		send_set('{maxv, minv, 0, -1, 1});
		send_set('{5, 5, -5, 5, minv, minv});
		send_set('{32'sh5555_5555, -32'sh5555_5556, 32'sh2AAA_AAAA, -32'sh2AAA_AAAB});
		send_set('{0, 0});
		wait_all_sorted();

		set_no = 0;
		while (items_sent < ITEM_TARGET) begin
			quiet = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (set_no == 0 || pick == 0)
				size = SET_CAP;
			else if (set_no == 1 || pick == 1)
				size = SET_CAP + $urandom_range(1, 16);
			else if (pick < 4)
				size = $urandom_range(9, 40);
			else
				size = $urandom_range(1, 8);
			send_random_set(size);
			if (set_no == 2 || $urandom_range(0, 9) == 0)
				wait_all_sorted();
			set_no++;
		end

		wait_all_sorted();
		repeat (SET_CAP + 10) @(posedge clk);
		if (tracker.pending() != 0)
			$error("%0d sorted results never arrived", tracker.pending());
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
